[src/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, character codes and helpers shared by the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   typedef enum logic [8:0] {
      PH_SIZE    = 9'b000000001,
      PH_EXT     = 9'b000000010,
      PH_SIZE_LF = 9'b000000100,
      PH_DATA    = 9'b000001000,
      PH_SKIP1   = 9'b000010000,
      PH_SKIP2   = 9'b000100000,
      PH_TRAILER = 9'b001000000,
      PH_DONE    = 9'b010000000,
      PH_ERROR   = 9'b100000000
   } phase_type;

   typedef enum logic [1:0] {
      ST_BUSY  = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       chunk_end;
      status_type status;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.ok    = 1'b1;
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.ok    = 1'b1;
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.ok    = 1'b1;
         h.value = 4'(c - 8'h37);
      end
      return h;
   endfunction

endpackage

[src/hcbd_channels.sv]
// ----------------------------------------------------------------------------
// hcbd channels
// Valid/ready channels for raw body bytes in and decoded words out.
// ----------------------------------------------------------------------------
interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic       restart;
   logic [7:0] data_byte;

   modport source (output valid, output restart, output data_byte, input ready);
   modport sink   (input valid, input restart, input data_byte, output ready);
endinterface

interface hcbd_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic       chunk_end;
   logic [1:0] status;

   modport source (output valid, output payload_valid, output payload_byte,
                   output chunk_end, output status, input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input chunk_end, input status, output ready);
endinterface

[src/hcbd_parser.sv]
// ----------------------------------------------------------------------------
// hcbd_parser
// Parser state and one-byte step logic for the chunked body format.
// ----------------------------------------------------------------------------
module hcbd_parser import hcbd_pkg::*; #(
   parameter int SIZE_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       restart,
   input  logic [7:0] data_byte,
   output result_type result
);

   phase_type            phase_ff, phase_in, phase_cur;
   logic [SIZE_BITS-1:0] acc_ff, acc_in, acc_cur;
   logic [SIZE_BITS-1:0] rem_ff, rem_in, rem_cur, rem_dec;
   logic [1:0]           term_ff, term_in, term_cur;
   hex_type              hex;

   always_comb begin
      phase_cur = restart ? PH_SIZE : phase_ff;
      acc_cur   = restart ? '0 : acc_ff;
      rem_cur   = restart ? '0 : rem_ff;
      term_cur  = restart ? 2'd0 : term_ff;
      hex       = hex_decode(data_byte);
      rem_dec   = rem_cur - SIZE_BITS'(1);

      phase_in = phase_cur;
      acc_in   = acc_cur;
      rem_in   = rem_cur;
      term_in  = term_cur;
      result   = '0;
      result.status = ST_BUSY;

      unique case (phase_cur)
         PH_SIZE: begin
            if (hex.ok) begin
               if (acc_cur[SIZE_BITS-1 -: 4] != 4'd0) begin
                  phase_in = PH_ERROR;
               end else begin
                  acc_in = {acc_cur[SIZE_BITS-5:0], hex.value};
               end
            end else if (data_byte == CH_SEMI) begin
               phase_in = PH_EXT;
            end else if (data_byte == CH_CR) begin
               phase_in = PH_SIZE_LF;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_EXT: begin
            if (data_byte == CH_CR) begin
               phase_in = PH_SIZE_LF;
            end
         end
         PH_SIZE_LF: begin
            if (data_byte != CH_LF) begin
               phase_in = PH_ERROR;
            end else if (acc_cur == '0) begin
               term_in  = 2'd2;
               phase_in = PH_TRAILER;
            end else begin
               rem_in   = acc_cur;
               acc_in   = '0;
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = data_byte;
            rem_in = rem_dec;
            if (rem_dec == '0) begin
               result.chunk_end = 1'b1;
               phase_in = PH_SKIP1;
            end
         end
         PH_SKIP1: begin
            phase_in = PH_SKIP2;
         end
         PH_SKIP2: begin
            acc_in   = '0;
            phase_in = PH_SIZE;
         end
         PH_TRAILER: begin
            if (data_byte == CH_CR) begin
               term_in = (term_cur == 2'd2) ? 2'd3 : 2'd1;
            end else if (data_byte == CH_LF) begin
               if (term_cur == 2'd3) begin
                  term_in  = 2'd0;
                  phase_in = PH_DONE;
                  result.status = ST_DONE;
               end else if (term_cur == 2'd1) begin
                  term_in = 2'd2;
               end else begin
                  term_in = 2'd0;
               end
            end else begin
               term_in = 2'd0;
            end
         end
         PH_DONE, PH_ERROR: begin
            phase_in = PH_ERROR;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      if (phase_in == PH_ERROR) begin
         result = '0;
         result.status = ST_ERROR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIZE;
         acc_ff   <= '0;
         rem_ff   <= '0;
         term_ff  <= 2'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         rem_ff   <= rem_in;
         term_ff  <= term_in;
      end
   end

endmodule

[src/http_chunked_body_decoder.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP chunked body one byte per word into payload bytes.
//
//   channel  dir  handshake        payload
//   req_bus  in   valid / ready    restart, data_byte
//   rsp_bus  out  valid / ready    payload_valid, payload_byte, chunk_end, status
//
// One byte per cycle sustained while rsp_bus is not stalled; each taken byte goes
// through the input register, then the parser step into the result register.
// The parser step is a single pass through the phase logic and the size
// counter add/compare; both registers advance together.
// Reset clears the parser to the size-line phase and empties both registers.
// A stalled rsp_bus holds its word; req_bus stays ready while a slot is free.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder import hcbd_pkg::*; #(
   parameter int SIZE_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   hcbd_req_if.sink    req_bus,
   hcbd_rsp_if.source  rsp_bus
);

   logic       in_valid_ff;
   logic       in_restart_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result;
   logic       advance;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   hcbd_parser #(
      .SIZE_BITS (SIZE_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .restart   (in_restart_ff),
      .data_byte (in_byte_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_restart_ff <= req_bus.restart;
         in_byte_ff    <= req_bus.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.payload_valid = out_ff.payload_valid;
   assign rsp_bus.payload_byte  = out_ff.payload_byte;
   assign rsp_bus.chunk_end     = out_ff.chunk_end;
   assign rsp_bus.status        = out_ff.status;

endmodule

[src/hcbd_checker.sv]
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module hcbd_checker import hcbd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_payload_valid,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_chunk_end,
   input logic [1:0] rsp_status
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_byte)
         && $stable(rsp_status) && $stable(rsp_chunk_end))
      else $error("stalled result word changed");

   a_payload_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> rsp_status == ST_BUSY)
      else $error("payload byte with done or error status");

   a_end_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chunk_end |-> rsp_payload_valid)
      else $error("chunk end without payload byte");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_payload_byte == 8'd0)
      else $error("nonzero byte without payload flag");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_payload_valid (rsp_bus.payload_valid),
   .rsp_payload_byte  (rsp_bus.payload_byte),
   .rsp_chunk_end     (rsp_bus.chunk_end),
   .rsp_status        (rsp_bus.status)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for http_chunked_body_decoder. Feeds directed and
// random chunked bodies one byte per word. Both channels stall at random. An
// in-bench parser predicts the result word for each byte taken, and each
// result word is checked in order.
// ----------------------------------------------------------------------------
module testbench;
   import hcbd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIZE_BITS = 24;

   logic clock;
   logic reset;

   hcbd_req_if req_bus ();
   hcbd_rsp_if rsp_bus ();

   http_chunked_body_decoder #(.SIZE_BITS(SIZE_BITS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   phase_type            parse_phase = PH_SIZE;
   logic [SIZE_BITS-1:0] size_acc    = '0;
   logic [SIZE_BITS-1:0] data_left   = '0;
   logic [1:0]           crlf_match  = '0;

   result_type  expected_words[$];
   logic [7:0]  body_bytes[$];
   int          items_sent = 0;
   int          fail_count = 0;
   bit          no_idle    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int idle_len();
      int p;
      if (no_idle)
         return 0;
      p = $urandom_range(0, 99);
      if (p < 60)
         return 0;
      if (p < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic result_type decode_step(input logic rst, input logic [7:0] c);
      result_type r;
      logic [4:0] nib;
      r = '0;
      if (rst) begin
         parse_phase = PH_SIZE;
         size_acc    = '0;
         data_left   = '0;
         crlf_match  = '0;
      end
      nib = 5'd16;
      if (c >= 8'h30 && c <= 8'h39)
         nib = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66)
         nib = 5'(c - 8'h61 + 8'd10);
      else if (c >= 8'h41 && c <= 8'h46)
         nib = 5'(c - 8'h41 + 8'd10);
      case (parse_phase)
         PH_SIZE: begin
            if (nib != 5'd16) begin
               if (size_acc[SIZE_BITS-1 -: 4] != 4'd0)
                  parse_phase = PH_ERROR;
               else
                  size_acc = {size_acc[SIZE_BITS-5:0], nib[3:0]};
            end else if (c == CH_SEMI) begin
               parse_phase = PH_EXT;
            end else if (c == CH_CR) begin
               parse_phase = PH_SIZE_LF;
            end else begin
               parse_phase = PH_ERROR;
            end
         end
         PH_EXT: begin
            if (c == CH_CR)
               parse_phase = PH_SIZE_LF;
         end
         PH_SIZE_LF: begin
            if (c != CH_LF) begin
               parse_phase = PH_ERROR;
            end else if (size_acc == '0) begin
               crlf_match  = 2'd2;
               parse_phase = PH_TRAILER;
            end else begin
               data_left   = size_acc;
               size_acc    = '0;
               parse_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            r.payload_valid = 1'b1;
            r.payload_byte  = c;
            data_left       = data_left - 1'b1;
            if (data_left == '0) begin
               r.chunk_end = 1'b1;
               parse_phase = PH_SKIP1;
            end
         end
         PH_SKIP1: begin
            parse_phase = PH_SKIP2;
         end
         PH_SKIP2: begin
            size_acc    = '0;
            parse_phase = PH_SIZE;
         end
         PH_TRAILER: begin
            if (c == CH_CR) begin
               crlf_match = (crlf_match == 2'd2) ? 2'd3 : 2'd1;
            end else if (c == CH_LF) begin
               if (crlf_match == 2'd3) begin
                  crlf_match  = 2'd0;
                  parse_phase = PH_DONE;
                  r.status    = ST_DONE;
               end else if (crlf_match == 2'd1) begin
                  crlf_match = 2'd2;
               end else begin
                  crlf_match = 2'd0;
               end
            end else begin
               crlf_match = 2'd0;
            end
         end
         default: begin
            parse_phase = PH_ERROR;
         end
      endcase
      if (parse_phase == PH_ERROR) begin
         r        = '0;
         r.status = ST_ERROR;
      end
      return r;
   endfunction

   task automatic send_word(input logic rst, input logic [7:0] b);
      int gap;
      bit taken;
      gap = idle_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.restart   <= rst;
      req_bus.data_byte <= b;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_bus.ready;
         if (taken)
            expected_words.push_back(decode_step(rst, b));
         @(negedge clock);
      end
      items_sent++;
   endtask

   task automatic send_body(input bit first_restart);
      int k;
      for (k = 0; k < body_bytes.size(); k++)
         send_word((k == 0) ? first_restart : ($urandom_range(0, 299) == 0), body_bytes[k]);
      body_bytes.delete();
   endtask

   task automatic push_text(input string s);
      int k;
      for (k = 0; k < s.len(); k++)
         body_bytes.push_back(s[k]);
   endtask

   task automatic push_crlf();
      body_bytes.push_back(CH_CR);
      body_bytes.push_back(CH_LF);
   endtask

   task automatic push_hex(input logic [3:0] nib);
      if (nib < 4'd10)
         body_bytes.push_back(8'h30 + 8'(nib));
      else if ($urandom_range(0, 1))
         body_bytes.push_back(8'h41 + 8'(nib) - 8'd10);
      else
         body_bytes.push_back(8'h61 + 8'(nib) - 8'd10);
   endtask

   task automatic push_size_line(input int sz);
      int top;
      int k;
      logic [7:0] b;
      if (sz != 0 || $urandom_range(0, 1)) begin
         repeat ($urandom_range(0, 2)) body_bytes.push_back(8'h30);
         top = 0;
         for (k = 0; k < 8; k++)
            if (((sz >> (4 * k)) & 15) != 0)
               top = k;
         for (k = top; k >= 0; k--)
            push_hex(4'((sz >> (4 * k)) & 15));
      end
      if ($urandom_range(0, 3) == 0) begin
         body_bytes.push_back(CH_SEMI);
         repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom);
            if (b == CH_CR)
               b = CH_SEMI;
            body_bytes.push_back(b);
         end
      end
      push_crlf();
   endtask

   task automatic test_chunk_and_empty_size();
      push_text("2;e");
      push_crlf();
      body_bytes.push_back(8'h00);
      body_bytes.push_back(8'hFF);
      body_bytes.push_back(8'h00);
      body_bytes.push_back(8'hFF);
      push_crlf();
      push_crlf();
      body_bytes.push_back(8'h41);
      send_body(1'b1);
   endtask

   task automatic test_bad_bytes();
      push_text("aFg1");
      send_body(1'b1);
      body_bytes.push_back(8'h31);
      body_bytes.push_back(CH_CR);
      body_bytes.push_back(8'h78);
      send_body(1'b1);
   endtask

   task automatic test_size_limits();
      push_text("fFFFFF");
      push_crlf();
      body_bytes.push_back(8'h5A);
      body_bytes.push_back(CH_CR);
      send_body(1'b1);
      push_text("1000000");
      send_body(1'b1);
   endtask

   task automatic test_trailer();
      push_text("0");
      push_crlf();
      push_text("X");
      push_crlf();
      push_crlf();
      send_body(1'b1);
   endtask

   task automatic test_random_bodies();
      int stop_at;
      int p;
      int sz;
      int n;
      stop_at = items_sent + 1800;
      while (items_sent < stop_at) begin
         no_idle = ($urandom_range(0, 4) == 0);
         repeat ($urandom_range(0, 3)) begin
            p  = $urandom_range(0, 99);
            sz = (p < 80) ? $urandom_range(1, 8) :
                 (p < 97) ? $urandom_range(9, 64) : $urandom_range(65, 300);
            push_size_line(sz);
            repeat (sz) body_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 9) == 0) begin
               body_bytes.push_back(8'($urandom));
               body_bytes.push_back(8'($urandom));
            end else begin
               push_crlf();
            end
         end
         push_size_line(0);
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               repeat ($urandom_range(1, 10)) begin
                  p = $urandom_range(0, 99);
                  if (p < 5)
                     body_bytes.push_back(CH_CR);
                  else if (p < 10)
                     body_bytes.push_back(CH_LF);
                  else
                     body_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
               end
               push_crlf();
            end
         end
         push_crlf();
         p = $urandom_range(0, 99);
         if (p < 6) begin
            body_bytes[$urandom_range(0, body_bytes.size() - 1)] = 8'($urandom);
         end else if (p < 10) begin
            repeat ($urandom_range(1, 4)) body_bytes.push_back(8'($urandom));
         end else if (p < 13) begin
            body_bytes.delete();
            push_hex(4'($urandom_range(1, 15)));
            repeat ($urandom_range(6, 8)) push_hex(4'($urandom));
            push_crlf();
            repeat ($urandom_range(0, 3)) body_bytes.push_back(8'($urandom));
         end else if (p < 16) begin
            n = $urandom_range(1, body_bytes.size());
            while (body_bytes.size() > n)
               void'(body_bytes.pop_back());
         end
         send_body($urandom_range(0, 19) != 0);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(negedge clock);
         n = idle_len();
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result word: valid=%0d byte=%02h end=%0d status=%0d",
                        rsp_bus.payload_valid, rsp_bus.payload_byte, rsp_bus.chunk_end,
                        rsp_bus.status);
         end else begin
            want = expected_words.pop_front();
            if (want.payload_valid !== rsp_bus.payload_valid ||
                want.payload_byte !== rsp_bus.payload_byte ||
                want.chunk_end !== rsp_bus.chunk_end ||
                want.status !== rsp_bus.status) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: exp valid=%0d byte=%02h end=%0d status=%0d, act valid=%0d byte=%02h end=%0d status=%0d",
                           want.payload_valid, want.payload_byte, want.chunk_end, want.status,
                           rsp_bus.payload_valid, rsp_bus.payload_byte, rsp_bus.chunk_end,
                           rsp_bus.status);
            end
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.restart   = 1'b0;
      req_bus.data_byte = 8'h00;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_chunk_and_empty_size();
      test_bad_bytes();
      test_size_limits();
      test_trailer();
      test_random_bodies();
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
